// File: hdl/ust_pkg.sv
package ust_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] ENC_UTF8    = 3'd0;
    localparam logic [2:0] ENC_UTF16LE = 3'd1;
    localparam logic [2:0] ENC_UTF16BE = 3'd2;
    localparam logic [2:0] ENC_UTF32LE = 3'd3;
    localparam logic [2:0] ENC_UTF32BE = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
    localparam logic [2:0] ERR_TRUNC     = 3'd2;
    localparam logic [2:0] ERR_INVALID   = 3'd3;
    localparam logic [2:0] ERR_LONE_LEAD = 3'd4;
    localparam logic [2:0] ERR_LONE_TRAIL = 3'd5;
    localparam logic [2:0] ERR_UNMAPPABLE = 3'd6;
    localparam logic [2:0] ERR_END       = 3'd7;

    localparam logic [1:0] REG_SRC    = 2'd0;
    localparam logic [1:0] REG_DST    = 2'd1;
    localparam logic [1:0] REG_STRICT = 2'd2;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00fffd;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] error_kind;
        logic       run_last;
        logic       stream_done;
    } t_out;

    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  kind;
        logic        final_word;
        logic        done;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// File: hdl/unicode_stream_transcoder_unit.sv
// Streaming transcoder between UTF-8, UTF-16LE/BE, UTF-32LE/BE and ISO-8859-1. Source bytes
// enter one per word; the front collects them in a four-byte buffer and decodes one code point
// per cycle. It accepts a byte, then decodes, and takes no new byte until it has released
// every code point the byte completes, including further points after a broken sequence and
// the incomplete-end status when a last byte leaves a partial sequence. The front also
// waits while the queue is full. Decoded points wait in a queue of P_QUEUE_DEPTH entries;
// the back writes one destination byte per cycle, unless stalled, via an output register,
// so a code point yields 1 to 4 output words and wide destination encodings set the
// sustained rate. Configuration is written through i_cfg_we and clears the pending buffer.
module unicode_stream_transcoder_unit #(
    parameter int P_QUEUE_DEPTH = ust_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ust_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ust_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [2:0]    i_cfg_data
);
    import ust_pkg::*;

    logic [2:0] r_src, r_dst;
    logic       r_strict;
    logic       cfg_clear;
    logic       push, pop;
    t_job       push_job, head_job;
    t_qstat     qstat;

    assign cfg_clear = i_cfg_we && (i_cfg_index == REG_SRC || i_cfg_index == REG_DST
                                    || i_cfg_index == REG_STRICT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src    <= ENC_UTF8;
            r_dst    <= ENC_UTF8;
            r_strict <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SRC:    r_src    <= i_cfg_data;
                REG_DST:    r_dst    <= i_cfg_data;
                REG_STRICT: r_strict <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    ust_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_src      (r_src),
        .i_clear    (cfg_clear),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (qstat.full),
        .o_push     (push),
        .o_job      (push_job)
    );

    ust_queue #(.P_DEPTH(P_QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    ust_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dst       (r_dst),
        .i_strict    (r_strict),
        .i_empty     (qstat.empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && qstat.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && qstat.empty))
        else $error("pop from empty queue");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.stream_done) |-> o_out_data.run_last)
        else $error("stream done without run last");

    a_status_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.byte_valid) |->
            (o_out_data.error_kind != ERR_NONE && o_out_data.out_byte == 8'h00))
        else $error("status word without error kind");
endmodule

// File: hdl/ust_queue.sv
module ust_queue #(
    parameter int P_DEPTH = ust_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ust_pkg::t_job i_job,
    input  logic          i_pop,
    output ust_pkg::t_job o_job,
    output ust_pkg::t_qstat o_stat
);
    import ust_pkg::*;

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_job          r_mem [P_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_count == CW'(P_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// File: hdl/ust_front.sv
module ust_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_src,
    input  logic          i_clear,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ust_pkg::t_in  i_in_data,
    input  logic          i_full,
    output logic          o_push,
    output ust_pkg::t_job o_job
);
    import ust_pkg::*;

    typedef logic [3:0][7:0] t_buf;

    typedef struct packed {
        logic        need;
        logic [20:0] cp;
        logic [2:0]  kind;
        logic [2:0]  used;
    } t_dec;

    function automatic logic point_ok(input logic [20:0] v);
        return (v <= 21'h10ffff) && !(v >= 21'h00d800 && v <= 21'h00dfff);
    endfunction

    function automatic t_dec ust_decode(input t_buf b, input logic [2:0] cnt,
                                        input logic [2:0] src);
        t_dec        d;
        logic [20:0] v;
        logic [2:0]  len;
        logic        stop;
        logic [15:0] u0, u1;
        logic [31:0] w;
        d    = '0;
        v    = '0;
        len  = 3'd0;
        stop = 1'b0;
        u0   = (src == ENC_UTF16LE) ? {b[1], b[0]} : {b[0], b[1]};
        u1   = (src == ENC_UTF16LE) ? {b[3], b[2]} : {b[2], b[3]};
        w    = (src == ENC_UTF32LE) ? {b[3], b[2], b[1], b[0]} : {b[0], b[1], b[2], b[3]};
        case (src)
            ENC_UTF8: begin
                if (b[0] < 8'h80) begin
                    d.cp   = {13'd0, b[0]};
                    d.used = 3'd1;
                end else if (b[0] < 8'hc0 || b[0] >= 8'hf8) begin
                    d.kind = ERR_BAD_LEAD;
                    d.used = 3'd1;
                end else begin
                    len = (b[0] < 8'he0) ? 3'd2 : ((b[0] < 8'hf0) ? 3'd3 : 3'd4);
                    case (len)
                        3'd2:    v = {16'd0, b[0][4:0]};
                        3'd3:    v = {17'd0, b[0][3:0]};
                        default: v = {18'd0, b[0][2:0]};
                    endcase
                    for (int i = 1; i < 4; i++) begin
                        if (!stop && 3'(i) < len) begin
                            if (3'(i) >= cnt) begin
                                d.need = 1'b1;
                                stop   = 1'b1;
                            end else if (b[i][7:6] != 2'b10) begin
                                d.kind = ERR_TRUNC;
                                d.used = 3'(i);
                                stop   = 1'b1;
                            end else begin
                                v = {v[14:0], b[i][5:0]};
                            end
                        end
                    end
                    if (!stop) begin
                        d.used = len;
                        if (!point_ok(v) || (len == 3'd2 && v < 21'h80)
                            || (len == 3'd3 && v < 21'h800)
                            || (len == 3'd4 && v < 21'h10000)) begin
                            d.kind = ERR_INVALID;
                        end else begin
                            d.cp = v;
                        end
                    end
                end
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (cnt < 3'd2) begin
                    d.need = 1'b1;
                end else if (u0 < 16'hd800 || u0 > 16'hdfff) begin
                    d.cp   = {5'd0, u0};
                    d.used = 3'd2;
                end else if (u0 >= 16'hdc00) begin
                    d.kind = ERR_LONE_TRAIL;
                    d.used = 3'd2;
                end else if (cnt < 3'd4) begin
                    d.need = 1'b1;
                end else if (u1 >= 16'hdc00 && u1 <= 16'hdfff) begin
                    d.cp   = {1'b0, u0[9:0], u1[9:0]} + 21'h10000;
                    d.used = 3'd4;
                end else begin
                    d.kind = ERR_LONE_LEAD;
                    d.used = 3'd2;
                end
            end
            ENC_UTF32LE, ENC_UTF32BE: begin
                if (cnt < 3'd4) begin
                    d.need = 1'b1;
                end else begin
                    d.used = 3'd4;
                    if (w[31:21] == '0 && point_ok(w[20:0])) begin
                        d.cp = w[20:0];
                    end else begin
                        d.kind = ERR_INVALID;
                    end
                end
            end
            default: begin
                d.cp   = {13'd0, b[0]};
                d.used = 3'd1;
            end
        endcase
        return d;
    endfunction

    t_buf       r_buf;
    logic [2:0] r_cnt;
    logic       r_busy;
    logic       r_last;

    t_dec       dec, dec2;
    t_buf       shifted;
    logic [2:0] rem;
    logic [2:0] sidx [4];

    assign o_in_ready = !r_busy;
    assign rem        = r_cnt - dec.used;

    always_comb begin
        dec = ust_decode(r_buf, r_cnt, i_src);
        for (int i = 0; i < 4; i++) begin
            sidx[i]    = 3'(i) + dec.used;
            shifted[i] = (sidx[i] < 3'd4) ? r_buf[sidx[i][1:0]] : 8'h00;
        end
        dec2 = ust_decode(shifted, rem, i_src);
    end

    always_comb begin
        o_push = 1'b0;
        o_job  = '0;
        if (r_busy && !i_full) begin
            if (dec.need) begin
                o_push           = r_last;
                o_job.kind       = ERR_END;
                o_job.final_word = 1'b1;
                o_job.done       = 1'b1;
            end else begin
                o_push           = 1'b1;
                o_job.kind       = dec.kind;
                o_job.cp         = (dec.kind != ERR_NONE) ? CP_REPLACEMENT : dec.cp;
                o_job.final_word = (rem == '0) || (dec2.need && !r_last);
                o_job.done       = (rem == '0) && r_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !r_busy) begin
            r_buf[r_cnt[1:0]] <= i_in_data.in_byte;
        end else if (r_busy && !i_full && !dec.need) begin
            r_buf <= shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_last <= 1'b0;
        end else if (i_in_valid && !r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_busy <= 1'b1;
            r_last <= i_in_data.in_last;
        end else if (r_busy && dec.need) begin
            if (!r_last) begin
                r_busy <= 1'b0;
            end else if (!i_full) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end
        end else if (r_busy && !i_full) begin
            r_cnt <= rem;
            if (rem == '0 || (dec2.need && !r_last)) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

// File: hdl/ust_back.sv
module ust_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_dst,
    input  logic          i_strict,
    input  logic          i_empty,
    input  ust_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ust_pkg::t_out o_out_data
);
    import ust_pkg::*;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
        logic            bval;
        logic [2:0]      kind;
    } t_enc;

    function automatic t_enc ust_encode(input t_job j, input logic [2:0] dst,
                                        input logic strict);
        t_enc        e;
        logic [20:0] c;
        logic [15:0] hi, lo, u;
        c      = j.cp - 21'h10000;
        hi     = {6'b110110, c[19:10]};
        lo     = {6'b110111, c[9:0]};
        u      = j.cp[15:0];
        e      = '0;
        e.kind = j.kind;
        e.bval = 1'b1;
        e.cnt  = 3'd1;
        if (j.kind == ERR_END || (strict && j.kind != ERR_NONE)) begin
            e.bval = 1'b0;
        end else begin
            case (dst)
                ENC_UTF8: begin
                    if (j.cp < 21'h80) begin
                        e.bytes[0] = j.cp[7:0];
                    end else if (j.cp < 21'h800) begin
                        e.cnt      = 3'd2;
                        e.bytes[0] = {3'b110, j.cp[10:6]};
                        e.bytes[1] = {2'b10, j.cp[5:0]};
                    end else if (j.cp < 21'h10000) begin
                        e.cnt      = 3'd3;
                        e.bytes[0] = {4'b1110, j.cp[15:12]};
                        e.bytes[1] = {2'b10, j.cp[11:6]};
                        e.bytes[2] = {2'b10, j.cp[5:0]};
                    end else begin
                        e.cnt      = 3'd4;
                        e.bytes[0] = {5'b11110, j.cp[20:18]};
                        e.bytes[1] = {2'b10, j.cp[17:12]};
                        e.bytes[2] = {2'b10, j.cp[11:6]};
                        e.bytes[3] = {2'b10, j.cp[5:0]};
                    end
                end
                ENC_UTF16LE: begin
                    if (j.cp < 21'h10000) begin
                        e.cnt   = 3'd2;
                        e.bytes = {16'h0000, u[15:8], u[7:0]};
                    end else begin
                        e.cnt   = 3'd4;
                        e.bytes = {lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
                    end
                end
                ENC_UTF16BE: begin
                    if (j.cp < 21'h10000) begin
                        e.cnt   = 3'd2;
                        e.bytes = {16'h0000, u[7:0], u[15:8]};
                    end else begin
                        e.cnt   = 3'd4;
                        e.bytes = {lo[7:0], lo[15:8], hi[7:0], hi[15:8]};
                    end
                end
                ENC_UTF32LE: begin
                    e.cnt   = 3'd4;
                    e.bytes = {11'd0, j.cp};
                end
                ENC_UTF32BE: begin
                    e.cnt   = 3'd4;
                    e.bytes = {j.cp[7:0], j.cp[15:8], 3'd0, j.cp[20:16], 8'h00};
                end
                default: begin
                    if (j.cp > 21'hff) begin
                        e.bytes[0] = 8'h3f;
                        if (j.kind == ERR_NONE) begin
                            e.kind = ERR_UNMAPPABLE;
                            if (strict) begin
                                e.bval     = 1'b0;
                                e.bytes[0] = 8'h00;
                            end
                        end
                    end else begin
                        e.bytes[0] = j.cp[7:0];
                    end
                end
            endcase
        end
        return e;
    endfunction

    t_enc       r_enc;
    logic       r_busy;
    logic       r_final;
    logic       r_done;
    logic [1:0] r_idx;
    logic       r_ovalid;
    t_out       r_out;

    logic out_free, last_idx, step;

    assign out_free    = !r_ovalid || i_out_ready;
    assign last_idx    = ({1'b0, r_idx} == r_enc.cnt - 3'd1);
    assign step        = r_busy && out_free;
    assign o_pop       = !i_empty && (!r_busy || (step && last_idx));
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_enc   <= ust_encode(i_job, i_dst, i_strict);
            r_final <= i_job.final_word;
            r_done  <= i_job.done;
        end
        if (step) begin
            r_out.out_byte    <= r_enc.bval ? r_enc.bytes[r_idx] : 8'h00;
            r_out.byte_valid  <= r_enc.bval;
            r_out.error_kind  <= r_enc.kind;
            r_out.run_last    <= r_final && last_idx;
            r_out.stream_done <= r_done && r_final && last_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (step) begin
                r_ovalid <= 1'b1;
                r_idx    <= r_idx + 1'b1;
                if (last_idx) begin
                    r_busy <= 1'b0;
                    r_idx  <= '0;
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end
        end
    end
endmodule

// File: bench/unicode_stream_transcoder_unit_tb.sv
`timescale 1ns / 100ps

module unicode_stream_transcoder_unit_tb;
    import ust_pkg::*;

    localparam logic [2:0] ENC_LATIN1 = 3'd5;
    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out       o_out_data;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [2:0] i_cfg_data;

    unicode_stream_transcoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // transcoder state mirror
    logic [2:0] src_enc, dst_enc;
    logic       strict_on;
    logic [7:0] pend [4];
    int         pend_cnt;

    t_in  word_queue [$];
    t_out expected_bytes [$];
    int   mismatch_count;
    int   cycle_count;
    int   send_idle_pct, recv_idle_pct;
    int   hold_cycles;
    int   results_seen;
    int   words_sent;
    logic cfg_pending;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic bit point_valid(logic [31:0] cp);
        return cp <= 32'h10ffff && (cp < 32'hd800 || cp > 32'hdfff);
    endfunction

    function automatic void push_byte(logic [7:0] b, logic [2:0] kind);
        t_out r;
        r = '0;
        r.out_byte = b;
        r.byte_valid = 1'b1;
        r.error_kind = kind;
        expected_bytes = {expected_bytes, r};
    endfunction

    function automatic void push_status(logic [2:0] kind);
        t_out r;
        r = '0;
        r.error_kind = kind;
        expected_bytes = {expected_bytes, r};
    endfunction

    function automatic void push_unit16(logic [15:0] u, logic [2:0] kind);
        if (dst_enc == ENC_UTF16LE) begin
            push_byte(u[7:0], kind);
            push_byte(u[15:8], kind);
        end else begin
            push_byte(u[15:8], kind);
            push_byte(u[7:0], kind);
        end
    endfunction

    function automatic void encode_point(logic [31:0] cp, logic [2:0] kind);
        logic [31:0] v;
        case (dst_enc)
            ENC_UTF8: begin
                if (cp < 32'h80) begin
                    push_byte(cp[7:0], kind);
                end else if (cp < 32'h800) begin
                    push_byte(8'hc0 | cp[10:6], kind);
                    push_byte(8'h80 | cp[5:0], kind);
                end else if (cp < 32'h10000) begin
                    push_byte(8'he0 | cp[15:12], kind);
                    push_byte(8'h80 | cp[11:6], kind);
                    push_byte(8'h80 | cp[5:0], kind);
                end else begin
                    push_byte(8'hf0 | cp[20:18], kind);
                    push_byte(8'h80 | cp[17:12], kind);
                    push_byte(8'h80 | cp[11:6], kind);
                    push_byte(8'h80 | cp[5:0], kind);
                end
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (cp < 32'h10000) begin
                    push_unit16(cp[15:0], kind);
                end else begin
                    v = cp - 32'h10000;
                    push_unit16(16'hd800 | v[19:10], kind);
                    push_unit16(16'hdc00 | v[9:0], kind);
                end
            end
            ENC_UTF32LE: begin
                for (int i = 0; i < 4; i++) push_byte(cp[8*i +: 8], kind);
            end
            ENC_UTF32BE: begin
                for (int i = 3; i >= 0; i--) push_byte(cp[8*i +: 8], kind);
            end
            default: begin
                if (cp > 32'hff) begin
                    if (kind == ERR_NONE && strict_on) begin
                        push_status(ERR_UNMAPPABLE);
                    end else begin
                        push_byte(8'h3f, kind == ERR_NONE ? ERR_UNMAPPABLE : kind);
                    end
                end else begin
                    push_byte(cp[7:0], kind);
                end
            end
        endcase
    endfunction

    // decode one point from the pending bytes; returns 0 when more bytes are needed
    function automatic bit decode_pending(output logic [31:0] cp, output logic [2:0] kind,
                                          output int used);
        logic [31:0] v, u0, u1;
        int len;
        cp = '0;
        kind = ERR_NONE;
        used = 1;
        case (src_enc)
            ENC_UTF8: begin
                if (pend[0] < 8'h80) begin
                    cp = pend[0];
                    return 1;
                end
                if (pend[0] < 8'hc0 || pend[0] >= 8'hf8) begin
                    kind = ERR_BAD_LEAD;
                    return 1;
                end
                len = pend[0] < 8'he0 ? 2 : (pend[0] < 8'hf0 ? 3 : 4);
                v = pend[0] & (8'h7f >> len);
                for (int i = 1; i < len; i++) begin
                    if (i >= pend_cnt) return 0;
                    if (pend[i][7:6] != 2'b10) begin
                        kind = ERR_TRUNC;
                        used = i;
                        return 1;
                    end
                    v = (v << 6) | pend[i][5:0];
                end
                used = len;
                if (!point_valid(v) || (len == 2 && v < 32'h80) || (len == 3 && v < 32'h800)
                    || (len == 4 && v < 32'h10000)) kind = ERR_INVALID;
                else cp = v;
                return 1;
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (pend_cnt < 2) return 0;
                u0 = src_enc == ENC_UTF16LE ? {pend[1], pend[0]} : {pend[0], pend[1]};
                used = 2;
                if (u0 < 32'hd800 || u0 > 32'hdfff) begin
                    cp = u0;
                    return 1;
                end
                if (u0 >= 32'hdc00) begin
                    kind = ERR_LONE_TRAIL;
                    return 1;
                end
                if (pend_cnt < 4) return 0;
                u1 = src_enc == ENC_UTF16LE ? {pend[3], pend[2]} : {pend[2], pend[3]};
                if (u1 >= 32'hdc00 && u1 <= 32'hdfff) begin
                    cp = ((u0[9:0] << 10) | u1[9:0]) + 32'h10000;
                    used = 4;
                end else begin
                    kind = ERR_LONE_LEAD;
                end
                return 1;
            end
            ENC_UTF32LE, ENC_UTF32BE: begin
                if (pend_cnt < 4) return 0;
                v = src_enc == ENC_UTF32LE ? {pend[3], pend[2], pend[1], pend[0]}
                                           : {pend[0], pend[1], pend[2], pend[3]};
                used = 4;
                if (point_valid(v)) cp = v;
                else kind = ERR_INVALID;
                return 1;
            end
            default: begin
                cp = pend[0];
                return 1;
            end
        endcase
    endfunction

    function automatic void transcode_word(t_in w);
        logic [31:0] cp;
        logic [2:0]  kind;
        int          used, base;
        base = expected_bytes.size();
        if (pend_cnt > 3) pend_cnt = 0;
        pend[pend_cnt] = w.in_byte;
        pend_cnt++;
        while (pend_cnt > 0) begin
            if (!decode_pending(cp, kind, used)) break;
            if (used == 0 || used > pend_cnt) used = pend_cnt;
            for (int i = 0; i + used < 4; i++) pend[i] = pend[i + used];
            pend_cnt -= used;
            if (kind != ERR_NONE && strict_on) push_status(kind);
            else encode_point(kind != ERR_NONE ? 32'hfffd : cp, kind);
        end
        if (w.in_last) begin
            if (pend_cnt > 0) push_status(ERR_END);
            pend_cnt = 0;
        end
        if (expected_bytes.size() > base) begin
            expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
            expected_bytes[expected_bytes.size() - 1].stream_done = w.in_last;
        end
    endfunction

    task automatic report_mismatch(string what, t_out got, t_out exp);
        $display("mismatch %s: got byte %02h v%0b k%0d l%0b d%0b, expected %02h v%0b k%0d l%0b d%0b",
                 what, got.out_byte, got.byte_valid, got.error_kind, got.run_last,
                 got.stream_done, exp.out_byte, exp.byte_valid, exp.error_kind, exp.run_last,
                 exp.stream_done);
        mismatch_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                transcode_word(i_in_data);
                words_sent++;
            end
            if (word_queue.size() > 0 && !cfg_pending && $urandom_range(99) >= send_idle_pct)
            begin
                i_in_valid <= 1'b1;
                i_in_data <= word_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count++;
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected", o_out_data, '0);
                end else if (o_out_data !== expected_bytes[0]) begin
                    report_mismatch("field", o_out_data, expected_bytes[0]);
                    void'(expected_bytes.pop_front());
                end else begin
                    void'(expected_bytes.pop_front());
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= $urandom_range(99) >= recv_idle_pct;
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SRC: src_enc = val;
            REG_DST: dst_enc = val;
            default: strict_on = val[0];
        endcase
        pend_cnt = 0;
    endtask

    task automatic drain_all();
        wait (word_queue.size() == 0);
        cfg_pending = 1'b1;
        @(posedge i_clk);
        while (i_in_valid || expected_bytes.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic configure(logic [2:0] s, logic [2:0] d, logic st);
        drain_all();
        write_reg(REG_SRC, s);
        write_reg(REG_DST, d);
        write_reg(REG_STRICT, {2'b00, st});
        cfg_pending = 1'b0;
    endtask

    task automatic add_word(logic [7:0] b, logic l);
        t_in w;
        w.in_byte = b;
        w.in_last = l;
        word_queue = {word_queue, w};
    endtask

    // well-formed random point in the current source encoding, with some noise
    task automatic add_random_sequence();
        logic [31:0] cp, v;
        int pick;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: cp = $urandom_range(32'h7f);
            1: cp = $urandom_range(32'h7ff);
            2: cp = $urandom_range(32'hffff);
            default: cp = $urandom_range(32'h10ffff, 32'h10000);
        endcase
        if (pick < 15) begin
            add_word(8'($urandom_range(255)), $urandom_range(99) < 5);
            return;
        end
        if (pick < 22) cp = $urandom_range(32'hdfff, 32'hd800);
        if (pick < 25) cp = $urandom;
        case (src_enc)
            ENC_UTF8: begin
                if (cp < 32'h80) add_word(cp[7:0], 0);
                else if (cp < 32'h800) begin
                    add_word(8'hc0 | cp[10:6], 0); add_word(8'h80 | cp[5:0], 0);
                end else if (cp < 32'h10000) begin
                    add_word(8'he0 | cp[15:12], 0); add_word(8'h80 | cp[11:6], 0);
                    add_word(8'h80 | cp[5:0], 0);
                end else begin
                    add_word(8'hf0 | cp[20:18], 0); add_word(8'h80 | cp[17:12], 0);
                    add_word(8'h80 | cp[11:6], 0); add_word(8'h80 | cp[5:0], 0);
                end
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (cp < 32'h10000 || cp > 32'h10ffff) v = {cp[15:0], 16'h0};
                else begin
                    v = cp - 32'h10000;
                    v = {6'b110110, v[19:10], 6'b110111, v[9:0]};
                end
                for (int i = 0; i < (v[15:0] == 0 ? 1 : 2); i++) begin
                    if (src_enc == ENC_UTF16LE) begin
                        add_word(v[23-16*i -: 8], 0); add_word(v[31-16*i -: 8], 0);
                    end else begin
                        add_word(v[31-16*i -: 8], 0); add_word(v[23-16*i -: 8], 0);
                    end
                end
            end
            ENC_UTF32LE: for (int i = 0; i < 4; i++) add_word(cp[8*i +: 8], 0);
            ENC_UTF32BE: for (int i = 3; i >= 0; i--) add_word(cp[8*i +: 8], 0);
            default: add_word(cp[7:0], 0);
        endcase
    endtask

    initial begin
        logic [2:0] cfg_set [8][3];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_SRC;
        i_cfg_data = '0;
        src_enc = ENC_UTF8;
        dst_enc = ENC_UTF8;
        strict_on = 1'b0;
        pend_cnt = 0;
        mismatch_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        results_seen = 0;
        words_sent = 0;
        cfg_pending = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 55;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        configure(ENC_UTF8, ENC_UTF16BE, 0);

        // directed: ascii, multi-byte, bad lead, truncation, overlong, surrogate, end cut
        add_word(8'h00, 0); add_word(8'h7f, 0); add_word(8'hff, 0); add_word(8'h80, 0);
        add_word(8'hc3, 0); add_word(8'ha9, 0); add_word(8'he2, 0); add_word(8'h41, 0);
        add_word(8'hc0, 0); add_word(8'h80, 0); add_word(8'hed, 0); add_word(8'ha0, 0);
        add_word(8'h80, 0); add_word(8'hf4, 0); add_word(8'h8f, 0); add_word(8'hbf, 0);
        add_word(8'hbf, 0); add_word(8'hf0, 0); add_word(8'h9f, 1);
        configure(ENC_UTF16LE, ENC_LATIN1, 1);
        add_word(8'h00, 0); add_word(8'hdc, 0); add_word(8'h00, 0); add_word(8'hd8, 0);
        add_word(8'h41, 0); add_word(8'h00, 0); add_word(8'h34, 0); add_word(8'h12, 0);
        add_word(8'h3d, 0); add_word(8'hd8, 0); add_word(8'h00, 0); add_word(8'hde, 0);
        add_word(8'h3d, 1);
        configure(ENC_UTF32BE, 3'd7, 0);
        add_word(8'h00, 0); add_word(8'h11, 0); add_word(8'h00, 0); add_word(8'h00, 0);
        add_word(8'h00, 0); add_word(8'h00, 0); add_word(8'h01, 0); add_word(8'h00, 1);

        cfg_set[0] = '{ENC_UTF8, ENC_UTF32LE, 3'd0};
        cfg_set[1] = '{ENC_UTF16BE, ENC_UTF8, 3'd1};
        cfg_set[2] = '{ENC_UTF32LE, ENC_UTF16LE, 3'd0};
        cfg_set[3] = '{ENC_LATIN1, ENC_UTF32BE, 3'd1};
        cfg_set[4] = '{3'd6, ENC_UTF8, 3'd0};
        cfg_set[5] = '{ENC_UTF8, ENC_LATIN1, 3'd1};
        cfg_set[6] = '{ENC_UTF16LE, ENC_UTF16BE, 3'd0};
        cfg_set[7] = '{ENC_UTF32BE, ENC_UTF8, 3'd1};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 55;
                recv_idle_pct = 11;
            end
            if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure(cfg_set[ph][0], cfg_set[ph][1], cfg_set[ph][2][0]);
            if (ph == 1) hold_cycles = 300;
            for (int k = 0; k < 5; k++) add_random_sequence();
            add_word(8'($urandom_range(255)), 1);
        end
        drain_all();
        $display("sent %0d bytes over 11 encoding settings, checked %0d output words",
                 words_sent, results_seen);
        $display("covered utf-8/16/32 both byte orders, latin-1, strict and lenient errors");
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
